// ===== src/uniform_grid_neighbor_cells_macros.svh =====
// Assertion helpers shared by the RTL.
`ifndef UNIFORM_GRID_NEIGHBOR_CELLS_MACROS_SVH
`define UNIFORM_GRID_NEIGHBOR_CELLS_MACROS_SVH

// Implication checked at every clock edge outside reset.
`define UGNC_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("implication failed");

// Condition that must never hold outside reset.
`define UGNC_ASSERT_NEVER(label, clk, rst_n, expr) \
  label: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("forbidden condition seen");

`endif

// ===== src/ugnc_pkg.sv =====
package ugnc_pkg;

  localparam int MAX_CELLS_X_DEF  = 64;
  localparam int MAX_CELLS_Y_DEF  = 64;
  localparam int BUCKET_DEPTH_DEF = 16;

  localparam int POS_W   = 24;
  localparam int PIDX_W  = 12;
  localparam int RCELL_W = 6;
  localparam int SLOT_W  = 4;
  localparam int OCELL_W = 6;
  localparam int OCNT_W  = 5;
  localparam int GRID_W  = 7;
  localparam int NBR_N   = 9;
  localparam int NBR_W   = 4;

  typedef enum logic [1:0] {
    OP_CLEAR  = 2'd0,
    OP_INSERT = 2'd1,
    OP_QUERY  = 2'd2,
    OP_READ   = 2'd3
  } opcode_t;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_OUTSIDE = 2'd1,
    ST_FULL    = 2'd2,
    ST_EMPTY   = 2'd3
  } status_t;

  typedef enum logic [1:0] {
    REG_CELL_SIZE = 2'd0,
    REG_CELLS_X   = 2'd1,
    REG_CELLS_Y   = 2'd2
  } reg_idx_t;

  typedef enum logic [1:0] {
    DIR_ZERO = 2'd0,
    DIR_NEG  = 2'd1,
    DIR_POS  = 2'd2
  } dir_t;

  typedef struct packed {
    logic start;
  } div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } div_sts_t;

  // Neighbor order: center, left, right, lower, upper, then diagonals.
  function automatic dir_t nbr_dx(input logic [NBR_W-1:0] i);
    dir_t d;
    case (i) inside
      4'd1, 4'd5, 4'd6: d = DIR_NEG;
      4'd2, 4'd7, 4'd8: d = DIR_POS;
      default:          d = DIR_ZERO;
    endcase
    return d;
  endfunction

  function automatic dir_t nbr_dy(input logic [NBR_W-1:0] i);
    dir_t d;
    case (i) inside
      4'd3, 4'd5, 4'd7: d = DIR_NEG;
      4'd4, 4'd6, 4'd8: d = DIR_POS;
      default:          d = DIR_ZERO;
    endcase
    return d;
  endfunction

endpackage

// ===== src/ugnc_ram.sv =====
module ugnc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                                  clk,
  input  logic                                  we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                      wdata,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                      rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

// ===== src/ugnc_div.sv =====
module ugnc_div (
  input  logic                       clk,
  input  logic                       rst_n,
  input  ugnc_pkg::div_ctl_t         ctl,
  input  logic [ugnc_pkg::POS_W-1:0] dividend,
  input  logic [ugnc_pkg::POS_W-1:0] divisor,
  output ugnc_pkg::div_sts_t         sts,
  output logic [ugnc_pkg::POS_W-1:0] quotient
);

  localparam int W  = ugnc_pkg::POS_W;
  localparam int CW = $clog2(W + 1);

  logic [W-1:0]  rem_r, rem_nxt;
  logic [W-1:0]  quo_r, quo_nxt;
  logic [W-1:0]  dsr_r, dsr_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;
  logic [W:0]    shifted;
  logic [W:0]    trial;

  // Restoring division, one quotient bit a cycle.
  always_comb begin
    rem_nxt  = rem_r;
    quo_nxt  = quo_r;
    dsr_nxt  = dsr_r;
    cnt_nxt  = cnt_r;
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    shifted  = {rem_r, quo_r[W-1]};
    trial    = shifted - {1'b0, dsr_r};
    if (ctl.start) begin
      rem_nxt  = '0;
      quo_nxt  = dividend;
      dsr_nxt  = divisor;
      cnt_nxt  = '0;
      busy_nxt = 1'b1;
    end else if (busy_r) begin
      if (!trial[W]) begin
        rem_nxt = trial[W-1:0];
        quo_nxt = {quo_r[W-2:0], 1'b1};
      end else begin
        rem_nxt = shifted[W-1:0];
        quo_nxt = {quo_r[W-2:0], 1'b0};
      end
      cnt_nxt = cnt_r + 1'b1;
      if (cnt_r == CW'(W - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    quo_r <= quo_nxt;
    dsr_r <= dsr_nxt;
  end

  assign sts.busy = busy_r;
  assign sts.done = done_r;
  assign quotient = quo_r;

endmodule

// ===== src/uniform_grid_neighbor_cells.sv =====
// Uniform-grid bin store for particle neighbor search.
// Input channel in_*: one command item; in_tuser holds the opcode (clear,
// insert, query, read). Result channel out_*: cell, count, stored index,
// with status in out_tuser and out_tlast on the final result of a command.
// cfg_*: write cell size and active grid size while no command is running.
// Cell coordinates come from one shared restoring divider, one quotient bit
// per cycle, x first and then y. Cell counts and bucket entries
// sit in two RAMs with registered reads, read one address at a time.
// A clear zeroes one count per cycle. A query reports its own cell and
// then each neighbor inside the grid, skipping the rest, up to nine
// results in all.
// in_tready is high only while the block is idle; one command at a time.
// After reset all MAX_CELLS_X*MAX_CELLS_Y counts (4096 by default) are swept
// to zero, one per cycle, with in_tready low; config writes still land.
// A stalled receiver holds the result in the output register and the
// sequencer waits; nothing is dropped or repeated.
`include "uniform_grid_neighbor_cells_macros.svh"

module uniform_grid_neighbor_cells #(
  parameter int MAX_CELLS_X  = ugnc_pkg::MAX_CELLS_X_DEF,
  parameter int MAX_CELLS_Y  = ugnc_pkg::MAX_CELLS_Y_DEF,
  parameter int BUCKET_DEPTH = ugnc_pkg::BUCKET_DEPTH_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // particle_index[11:0], pos_x[35:12], pos_y[59:36], read_cell_x[65:60],
  // read_cell_y[71:66], slot[75:72], zero pad [79:76]
  input  logic [79:0] in_tdata,
  // opcode[1:0]
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // cell_x[5:0], cell_y[11:6], count[16:12], stored_index[28:17], pad [31:29]
  output logic [31:0] out_tdata,
  // status[1:0]
  output logic [1:0]  out_tuser,
  output logic        out_tlast,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [23:0] cfg_wdata
);

  localparam int POS_W  = ugnc_pkg::POS_W;
  localparam int NC     = MAX_CELLS_X * MAX_CELLS_Y;
  localparam int NB     = NC * BUCKET_DEPTH;
  localparam int AW     = NC > 1 ? $clog2(NC) : 1;
  localparam int BAW    = NB > 1 ? $clog2(NB) : 1;
  localparam int XW     = MAX_CELLS_X > 1 ? $clog2(MAX_CELLS_X) : 1;
  localparam int YW     = MAX_CELLS_Y > 1 ? $clog2(MAX_CELLS_Y) : 1;
  localparam int NXW    = $clog2(MAX_CELLS_X + 1);
  localparam int NYW    = $clog2(MAX_CELLS_Y + 1);
  localparam int CW     = $clog2(BUCKET_DEPTH + 1);
  localparam int PIDX_W = ugnc_pkg::PIDX_W;
  localparam int NBR_W  = ugnc_pkg::NBR_W;
  localparam int NBR_N  = ugnc_pkg::NBR_N;

  typedef enum logic [8:0] {
    S_CLR   = 9'b000000001,
    S_IDLE  = 9'b000000010,
    S_DIVX  = 9'b000000100,
    S_DIVY  = 9'b000001000,
    S_NBR   = 9'b000010000,
    S_RDCHK = 9'b000100000,
    S_CRD   = 9'b001000000,
    S_CWAIT = 9'b010000000,
    S_OUT   = 9'b100000000
  } state_t;

  state_t state_r, state_nxt;

  // Configuration.
  logic [POS_W-1:0]           cell_size_r;
  logic [ugnc_pkg::GRID_W-1:0] cells_x_r, cells_y_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cell_size_r <= POS_W'(4096);
      cells_x_r   <= ugnc_pkg::GRID_W'(64);
      cells_y_r   <= ugnc_pkg::GRID_W'(64);
    end else if (cfg_we) begin
      unique case (cfg_index)
        ugnc_pkg::REG_CELL_SIZE: cell_size_r <= cfg_wdata;
        ugnc_pkg::REG_CELLS_X:   cells_x_r   <= cfg_wdata[ugnc_pkg::GRID_W-1:0];
        ugnc_pkg::REG_CELLS_Y:   cells_y_r   <= cfg_wdata[ugnc_pkg::GRID_W-1:0];
        default: ;
      endcase
    end
  end

  // Active grid size: zero reads as one, oversize saturates.
  logic [NXW-1:0]   nx;
  logic [NYW-1:0]   ny;
  logic [POS_W-1:0] cs;

  always_comb begin
    if (cells_x_r == '0) begin
      nx = NXW'(1);
    end else if (32'(cells_x_r) > 32'(MAX_CELLS_X)) begin
      nx = NXW'(MAX_CELLS_X);
    end else begin
      nx = NXW'(cells_x_r);
    end
    if (cells_y_r == '0) begin
      ny = NYW'(1);
    end else if (32'(cells_y_r) > 32'(MAX_CELLS_Y)) begin
      ny = NYW'(MAX_CELLS_Y);
    end else begin
      ny = NYW'(cells_y_r);
    end
    cs = (cell_size_r == '0) ? POS_W'(1) : cell_size_r;
  end

  // Input fields.
  logic [PIDX_W-1:0]            in_pidx;
  logic [POS_W-1:0]             in_px, in_py;
  logic [ugnc_pkg::RCELL_W-1:0] in_rx, in_ry;
  logic [ugnc_pkg::SLOT_W-1:0]  in_slot;

  assign in_pidx = in_tdata[11:0];
  assign in_px   = in_tdata[35:12];
  assign in_py   = in_tdata[59:36];
  assign in_rx   = in_tdata[65:60];
  assign in_ry   = in_tdata[71:66];
  assign in_slot = in_tdata[75:72];

  // Held command.
  ugnc_pkg::opcode_t            op_r, op_nxt;
  logic [PIDX_W-1:0]            pidx_r, pidx_nxt;
  logic [POS_W-1:0]             py_r, py_nxt;
  logic [ugnc_pkg::RCELL_W-1:0] rx_r, rx_nxt, ry_r, ry_nxt;
  logic [ugnc_pkg::SLOT_W-1:0]  slot_r, slot_nxt;
  logic [POS_W-1:0]             qx_r, qx_nxt;
  logic [XW-1:0]                base_x_r, base_x_nxt, cur_x_r, cur_x_nxt;
  logic [YW-1:0]                base_y_r, base_y_nxt, cur_y_r, cur_y_nxt;
  logic [NBR_N-1:0]             mask_r, mask_nxt;
  logic [NBR_W-1:0]             nbr_r, nbr_nxt;
  logic [AW-1:0]                clr_r, clr_nxt;
  logic                         reply_r, reply_nxt;
  logic                         more_r, more_nxt;

  // Output register.
  logic [ugnc_pkg::OCELL_W-1:0] o_x_r, o_x_nxt, o_y_r, o_y_nxt;
  logic [ugnc_pkg::OCNT_W-1:0]  o_cnt_r, o_cnt_nxt;
  logic [PIDX_W-1:0]            o_idx_r, o_idx_nxt;
  ugnc_pkg::status_t            o_st_r, o_st_nxt;
  logic                         o_last_r, o_last_nxt;

  // Divider.
  ugnc_pkg::div_ctl_t div_ctl;
  ugnc_pkg::div_sts_t div_sts;
  logic [POS_W-1:0]   div_dividend;
  logic [POS_W-1:0]   div_quo;

  assign div_dividend = (state_r == S_IDLE) ? in_px : py_r;

  ugnc_div u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .ctl      (div_ctl),
    .dividend (div_dividend),
    .divisor  (cs),
    .sts      (div_sts),
    .quotient (div_quo)
  );

  // Memories: addresses follow the current cell, but for the clear sweep.
  logic [AW-1:0]     cell_id;
  logic              cnt_we;
  logic [AW-1:0]     cnt_waddr;
  logic [CW-1:0]     cnt_wdata;
  logic [CW-1:0]     cnt_rdata;
  logic              bkt_we;
  logic [BAW-1:0]    bkt_waddr, bkt_raddr;
  logic [PIDX_W-1:0] bkt_rdata;

  assign cell_id   = AW'(32'(cur_x_r) * MAX_CELLS_Y + 32'(cur_y_r));
  assign bkt_waddr = BAW'(32'(cell_id) * BUCKET_DEPTH + 32'(cnt_rdata));
  assign bkt_raddr = BAW'(32'(cell_id) * BUCKET_DEPTH + 32'(slot_r));

  ugnc_ram #(.WIDTH(CW), .DEPTH(NC)) u_counts (
    .clk   (clk),
    .we    (cnt_we),
    .waddr (cnt_waddr),
    .wdata (cnt_wdata),
    .raddr (cell_id),
    .rdata (cnt_rdata)
  );

  ugnc_ram #(.WIDTH(PIDX_W), .DEPTH(NB)) u_buckets (
    .clk   (clk),
    .we    (bkt_we),
    .waddr (bkt_waddr),
    .wdata (pidx_r),
    .raddr (bkt_raddr),
    .rdata (bkt_rdata)
  );

  // Neighbor validity for the cell leaving the divider.
  logic [XW-1:0]    new_x;
  logic [YW-1:0]    new_y;
  logic [NBR_N-1:0] new_mask;
  logic             nbr_last;
  ugnc_pkg::dir_t   dx, dy;

  always_comb begin
    new_x = XW'(qx_r);
    new_y = YW'(div_quo);
    for (int i = 0; i < NBR_N; i++) begin
      new_mask[i] = 1'b1;
      if (ugnc_pkg::nbr_dx(NBR_W'(i)) == ugnc_pkg::DIR_NEG && new_x == '0) begin
        new_mask[i] = 1'b0;
      end
      if (ugnc_pkg::nbr_dx(NBR_W'(i)) == ugnc_pkg::DIR_POS &&
          32'(new_x) + 1 >= 32'(nx)) begin
        new_mask[i] = 1'b0;
      end
      if (ugnc_pkg::nbr_dy(NBR_W'(i)) == ugnc_pkg::DIR_NEG && new_y == '0) begin
        new_mask[i] = 1'b0;
      end
      if (ugnc_pkg::nbr_dy(NBR_W'(i)) == ugnc_pkg::DIR_POS &&
          32'(new_y) + 1 >= 32'(ny)) begin
        new_mask[i] = 1'b0;
      end
    end
    nbr_last = 1'b1;
    for (int j = 0; j < NBR_N; j++) begin
      if (32'(j) > 32'(nbr_r) && mask_r[j]) begin
        nbr_last = 1'b0;
      end
    end
    dx = ugnc_pkg::nbr_dx(nbr_r);
    dy = ugnc_pkg::nbr_dy(nbr_r);
  end

  // Sequencer.
  always_comb begin
    state_nxt  = state_r;
    op_nxt     = op_r;
    pidx_nxt   = pidx_r;
    py_nxt     = py_r;
    rx_nxt     = rx_r;
    ry_nxt     = ry_r;
    slot_nxt   = slot_r;
    qx_nxt     = qx_r;
    base_x_nxt = base_x_r;
    base_y_nxt = base_y_r;
    cur_x_nxt  = cur_x_r;
    cur_y_nxt  = cur_y_r;
    mask_nxt   = mask_r;
    nbr_nxt    = nbr_r;
    clr_nxt    = clr_r;
    reply_nxt  = reply_r;
    more_nxt   = more_r;
    o_x_nxt    = o_x_r;
    o_y_nxt    = o_y_r;
    o_cnt_nxt  = o_cnt_r;
    o_idx_nxt  = o_idx_r;
    o_st_nxt   = o_st_r;
    o_last_nxt = o_last_r;
    div_ctl    = '0;
    cnt_we     = 1'b0;
    cnt_waddr  = cell_id;
    cnt_wdata  = '0;
    bkt_we     = 1'b0;

    unique case (state_r)
      S_CLR: begin
        // Zero one count per cycle.
        cnt_we    = 1'b1;
        cnt_waddr = clr_r;
        if (clr_r == AW'(NC - 1)) begin
          if (reply_r) begin
            o_x_nxt    = '0;
            o_y_nxt    = '0;
            o_cnt_nxt  = '0;
            o_idx_nxt  = '0;
            o_st_nxt   = ugnc_pkg::ST_OK;
            o_last_nxt = 1'b1;
            more_nxt   = 1'b0;
            state_nxt  = S_OUT;
          end else begin
            state_nxt = S_IDLE;
          end
        end else begin
          clr_nxt = clr_r + 1'b1;
        end
      end

      S_IDLE: begin
        if (in_tvalid) begin
          op_nxt   = ugnc_pkg::opcode_t'(in_tuser);
          pidx_nxt = in_pidx;
          py_nxt   = in_py;
          rx_nxt   = in_rx;
          ry_nxt   = in_ry;
          slot_nxt = in_slot;
          unique case (ugnc_pkg::opcode_t'(in_tuser))
            ugnc_pkg::OP_CLEAR: begin
              clr_nxt   = '0;
              reply_nxt = 1'b1;
              state_nxt = S_CLR;
            end
            ugnc_pkg::OP_READ: begin
              state_nxt = S_RDCHK;
            end
            default: begin
              div_ctl.start = 1'b1;
              state_nxt     = S_DIVX;
            end
          endcase
        end
      end

      S_DIVX: begin
        if (div_sts.done) begin
          qx_nxt        = div_quo;
          div_ctl.start = 1'b1;
          state_nxt     = S_DIVY;
        end
      end

      S_DIVY: begin
        if (div_sts.done) begin
          if (qx_r >= POS_W'(nx) || div_quo >= POS_W'(ny)) begin
            o_x_nxt    = '0;
            o_y_nxt    = '0;
            o_cnt_nxt  = '0;
            o_idx_nxt  = '0;
            o_st_nxt   = ugnc_pkg::ST_OUTSIDE;
            o_last_nxt = 1'b1;
            more_nxt   = 1'b0;
            state_nxt  = S_OUT;
          end else begin
            base_x_nxt = new_x;
            base_y_nxt = new_y;
            cur_x_nxt  = new_x;
            cur_y_nxt  = new_y;
            mask_nxt   = new_mask;
            nbr_nxt    = '0;
            state_nxt  = (op_r == ugnc_pkg::OP_INSERT) ? S_CRD : S_NBR;
          end
        end
      end

      S_NBR: begin
        // Skip neighbors outside the grid; the center is always inside.
        if (mask_r[nbr_r]) begin
          unique case (dx)
            ugnc_pkg::DIR_NEG: cur_x_nxt = base_x_r - 1'b1;
            ugnc_pkg::DIR_POS: cur_x_nxt = base_x_r + 1'b1;
            default:           cur_x_nxt = base_x_r;
          endcase
          unique case (dy)
            ugnc_pkg::DIR_NEG: cur_y_nxt = base_y_r - 1'b1;
            ugnc_pkg::DIR_POS: cur_y_nxt = base_y_r + 1'b1;
            default:           cur_y_nxt = base_y_r;
          endcase
          state_nxt = S_CRD;
        end else begin
          nbr_nxt = nbr_r + 1'b1;
        end
      end

      S_RDCHK: begin
        if (32'(rx_r) >= 32'(nx) || 32'(ry_r) >= 32'(ny)) begin
          o_x_nxt    = rx_r;
          o_y_nxt    = ry_r;
          o_cnt_nxt  = '0;
          o_idx_nxt  = '0;
          o_st_nxt   = ugnc_pkg::ST_OUTSIDE;
          o_last_nxt = 1'b1;
          more_nxt   = 1'b0;
          state_nxt  = S_OUT;
        end else begin
          cur_x_nxt = XW'(rx_r);
          cur_y_nxt = YW'(ry_r);
          state_nxt = S_CRD;
        end
      end

      S_CRD: begin
        // Count and bucket addresses are presented; data lands next cycle.
        state_nxt = S_CWAIT;
      end

      S_CWAIT: begin
        o_x_nxt    = ugnc_pkg::OCELL_W'(cur_x_r);
        o_y_nxt    = ugnc_pkg::OCELL_W'(cur_y_r);
        o_cnt_nxt  = ugnc_pkg::OCNT_W'(cnt_rdata);
        o_idx_nxt  = '0;
        o_st_nxt   = ugnc_pkg::ST_OK;
        o_last_nxt = 1'b1;
        more_nxt   = 1'b0;
        state_nxt  = S_OUT;
        unique case (op_r)
          ugnc_pkg::OP_INSERT: begin
            if (32'(cnt_rdata) >= 32'(BUCKET_DEPTH)) begin
              o_st_nxt = ugnc_pkg::ST_FULL;
            end else begin
              bkt_we    = 1'b1;
              cnt_we    = 1'b1;
              cnt_wdata = cnt_rdata + 1'b1;
              o_cnt_nxt = ugnc_pkg::OCNT_W'(cnt_rdata + 1'b1);
            end
          end
          ugnc_pkg::OP_QUERY: begin
            o_last_nxt = nbr_last;
            more_nxt   = !nbr_last;
          end
          default: begin
            if (32'(slot_r) >= 32'(cnt_rdata) || 32'(slot_r) >= 32'(BUCKET_DEPTH)) begin
              o_st_nxt = ugnc_pkg::ST_EMPTY;
            end else begin
              o_idx_nxt = bkt_rdata;
            end
          end
        endcase
      end

      S_OUT: begin
        // Hold the result until taken.
        if (out_tready) begin
          if (more_r) begin
            nbr_nxt   = nbr_r + 1'b1;
            state_nxt = S_NBR;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLR;
      clr_r   <= '0;
      reply_r <= 1'b0;
      more_r  <= 1'b0;
      nbr_r   <= '0;
    end else begin
      state_r <= state_nxt;
      clr_r   <= clr_nxt;
      reply_r <= reply_nxt;
      more_r  <= more_nxt;
      nbr_r   <= nbr_nxt;
    end
    op_r     <= op_nxt;
    pidx_r   <= pidx_nxt;
    py_r     <= py_nxt;
    rx_r     <= rx_nxt;
    ry_r     <= ry_nxt;
    slot_r   <= slot_nxt;
    qx_r     <= qx_nxt;
    base_x_r <= base_x_nxt;
    base_y_r <= base_y_nxt;
    cur_x_r  <= cur_x_nxt;
    cur_y_r  <= cur_y_nxt;
    mask_r   <= mask_nxt;
    o_x_r    <= o_x_nxt;
    o_y_r    <= o_y_nxt;
    o_cnt_r  <= o_cnt_nxt;
    o_idx_r  <= o_idx_nxt;
    o_st_r   <= o_st_nxt;
    o_last_r <= o_last_nxt;
  end

  assign in_tready  = (state_r == S_IDLE);
  assign out_tvalid = (state_r == S_OUT);
  assign out_tdata  = {3'b000, o_idx_r, o_cnt_r, o_y_r, o_x_r};
  assign out_tuser  = o_st_r;
  assign out_tlast  = o_last_r;

  `UGNC_ASSERT_NEVER(a_ready_while_result, clk, rst_n, in_tready && out_tvalid)
  `UGNC_ASSERT_IMPL(a_div_done_in_div, clk, rst_n, div_sts.done,
                    state_r == S_DIVX || state_r == S_DIVY)
  `UGNC_ASSERT_IMPL(a_center_in_mask, clk, rst_n, state_r == S_NBR, mask_r[0])
  `UGNC_ASSERT_IMPL(a_more_not_last, clk, rst_n, out_tvalid, more_r != out_tlast)

endmodule
